/* hdl/jsu_pkg.sv */
// Types, character codes and helpers shared by the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

	// Decoder phase
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_STR  = 2'd1;
	localparam logic [1:0] PH_ESC  = 2'd2;
	localparam logic [1:0] PH_UNI  = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
	localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
	localparam logic [2:0] ERR_END_ESC  = 3'd3;
	localparam logic [2:0] ERR_SHORT_U  = 3'd4;
	localparam logic [2:0] ERR_UNTERM   = 3'd5;

	// Characters
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam logic [15:0] ASCII_LIMIT = 16'h0080;

	// Most results one item can cause: six pass-through bytes and an error
	localparam int unsigned MAX_RES = 7;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       done;
		logic [2:0] err;
	} result_t;

	typedef struct packed {
		logic [2:0]                n;
		result_t [MAX_RES-1:0]     res;
		logic [1:0]                phase;
		logic [1:0]                dcnt;
		logic                      hold_we;
	} step_t;

	// {is hex digit, nibble}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = 5'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				r = {1'b1, c[3:0]};
			end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
				r = {1'b1, c[3:0] + 4'd9};
			end
			return r;
		end
	endfunction

	function automatic result_t byte_res(input logic [7:0] d);
		result_t r;
		begin
			r = '{data: d, has: 1'b1, done: 1'b0, err: ERR_NONE};
			return r;
		end
	endfunction

	function automatic result_t err_res(input logic [2:0] e);
		result_t r;
		begin
			r = '{data: 8'd0, has: 1'b0, done: 1'b0, err: e};
			return r;
		end
	endfunction

endpackage

/* hdl/jsu_in_if.sv */
// Input channel: raw text bytes.
`timescale 1ns / 1ps

interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_ends;

	modport source (output valid, output in_byte, output text_ends, input ready);
	modport sink   (input valid, input in_byte, input text_ends, output ready);
endinterface

/* hdl/jsu_out_if.sv */
// Output channel: decoded results.
`timescale 1ns / 1ps

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       string_done;
	logic [2:0] error_code;
	logic       last_of_run;

	modport source (output valid, output out_byte, output has_byte, output string_done,
		output error_code, output last_of_run, input ready);
	modport sink   (input valid, input out_byte, input has_byte, input string_done,
		input error_code, input last_of_run, output ready);
endinterface

/* hdl/jsu_step.sv */
// Decode of one text byte: next state and the run of results it causes.
`timescale 1ns / 1ps

module jsu_step (
	input  logic [1:0]      phase,
	input  logic [1:0]      dcnt,
	input  logic [7:0]      held0,
	input  logic [7:0]      held1,
	input  logic [7:0]      held2,
	input  logic [7:0]      in_byte,
	input  logic            text_ends,
	output jsu_pkg::step_t  step
);

	logic [4:0]  h0, h1, h2, h3;
	logic [15:0] uval;
	logic        produced;
	logic [7:0]  esc_map;
	logic        esc_ok;
	logic [2:0]  n_base;
	jsu_pkg::step_t s;

	assign h0 = jsu_pkg::hex_nib(held0);
	assign h1 = jsu_pkg::hex_nib(held1);
	assign h2 = jsu_pkg::hex_nib(held2);
	assign h3 = jsu_pkg::hex_nib(in_byte);

	// value of the leading hex digits only
	always_comb begin
		if (!h0[4])      uval = 16'd0;
		else if (!h1[4]) uval = {12'd0, h0[3:0]};
		else if (!h2[4]) uval = {8'd0, h0[3:0], h1[3:0]};
		else if (!h3[4]) uval = {4'd0, h0[3:0], h1[3:0], h2[3:0]};
		else             uval = {h0[3:0], h1[3:0], h2[3:0], h3[3:0]};
	end

	always_comb begin
		esc_ok = 1'b1;
		case (in_byte)
			jsu_pkg::CH_QUOTE: esc_map = jsu_pkg::CH_QUOTE;
			jsu_pkg::CH_BSL:   esc_map = jsu_pkg::CH_BSL;
			jsu_pkg::CH_SLASH: esc_map = jsu_pkg::CH_SLASH;
			jsu_pkg::CH_B:     esc_map = jsu_pkg::CH_BS;
			jsu_pkg::CH_F:     esc_map = jsu_pkg::CH_FF;
			jsu_pkg::CH_N:     esc_map = jsu_pkg::CH_LF;
			jsu_pkg::CH_R:     esc_map = jsu_pkg::CH_CR;
			jsu_pkg::CH_T:     esc_map = jsu_pkg::CH_TAB;
			default: begin
				esc_map = 8'd0;
				esc_ok  = 1'b0;
			end
		endcase
	end

	always_comb begin
		s          = '0;
		s.phase    = phase;
		s.dcnt     = dcnt;
		s.hold_we  = 1'b0;
		produced   = 1'b0;
		unique case (phase)
			jsu_pkg::PH_IDLE: begin
				if (in_byte != jsu_pkg::CH_QUOTE) begin
					s.res[0] = jsu_pkg::err_res(jsu_pkg::ERR_NO_QUOTE);
					s.n      = 3'd1;
				end else if (text_ends) begin
					s.res[0] = jsu_pkg::err_res(jsu_pkg::ERR_UNTERM);
					s.n      = 3'd1;
				end else begin
					s.phase = jsu_pkg::PH_STR;
				end
			end
			jsu_pkg::PH_STR: begin
				if (in_byte == jsu_pkg::CH_QUOTE) begin
					s.res[0] = '{data: 8'd0, has: 1'b0, done: 1'b1, err: jsu_pkg::ERR_NONE};
					s.n      = 3'd1;
					s.phase  = jsu_pkg::PH_IDLE;
					s.dcnt   = 2'd0;
				end else if (in_byte == jsu_pkg::CH_BSL) begin
					if (text_ends) begin
						s.res[0] = jsu_pkg::err_res(jsu_pkg::ERR_END_ESC);
						s.n      = 3'd1;
						s.phase  = jsu_pkg::PH_IDLE;
						s.dcnt   = 2'd0;
					end else begin
						s.phase = jsu_pkg::PH_ESC;
					end
				end else begin
					s.res[0] = jsu_pkg::byte_res(in_byte);
					s.n      = 3'd1;
					produced = 1'b1;
				end
			end
			jsu_pkg::PH_ESC: begin
				if (esc_ok) begin
					s.res[0] = jsu_pkg::byte_res(esc_map);
					s.n      = 3'd1;
					produced = 1'b1;
					s.phase  = jsu_pkg::PH_STR;
				end else if (in_byte == jsu_pkg::CH_U) begin
					if (text_ends) begin
						s.res[0] = jsu_pkg::err_res(jsu_pkg::ERR_SHORT_U);
						s.n      = 3'd1;
						s.phase  = jsu_pkg::PH_IDLE;
					end else begin
						s.phase = jsu_pkg::PH_UNI;
					end
					s.dcnt = 2'd0;
				end else begin
					s.res[0] = jsu_pkg::err_res(jsu_pkg::ERR_BAD_ESC);
					s.n      = 3'd1;
					s.phase  = jsu_pkg::PH_IDLE;
					s.dcnt   = 2'd0;
				end
			end
			jsu_pkg::PH_UNI: begin
				s.hold_we = 1'b1;
				if (dcnt != 2'd3) begin
					if (text_ends) begin
						s.res[0] = jsu_pkg::err_res(jsu_pkg::ERR_SHORT_U);
						s.n      = 3'd1;
						s.phase  = jsu_pkg::PH_IDLE;
						s.dcnt   = 2'd0;
					end else begin
						s.dcnt = dcnt + 2'd1;
					end
				end else begin
					if (uval != 16'd0 && uval < jsu_pkg::ASCII_LIMIT) begin
						s.res[0] = jsu_pkg::byte_res(uval[7:0]);
						s.n      = 3'd1;
					end else begin
						s.res[0] = jsu_pkg::byte_res(jsu_pkg::CH_BSL);
						s.res[1] = jsu_pkg::byte_res(jsu_pkg::CH_U);
						s.res[2] = jsu_pkg::byte_res(held0);
						s.res[3] = jsu_pkg::byte_res(held1);
						s.res[4] = jsu_pkg::byte_res(held2);
						s.res[5] = jsu_pkg::byte_res(in_byte);
						s.n      = 3'd6;
					end
					produced = 1'b1;
					s.phase  = jsu_pkg::PH_STR;
					s.dcnt   = 2'd0;
				end
			end
			default: s.phase = jsu_pkg::PH_IDLE;
		endcase

		// text ran out after decoded bytes: unterminated string follows them
		n_base = s.n;
		if (produced && text_ends) begin
			for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
				if (n_base == 3'(i)) s.res[i] = jsu_pkg::err_res(jsu_pkg::ERR_UNTERM);
			end
			s.n     = n_base + 3'd1;
			s.phase = jsu_pkg::PH_IDLE;
			s.dcnt  = 2'd0;
		end
	end

	assign step = s;

endmodule

/* hdl/json_string_unescape.sv */
// Top level of the streaming JSON string unescaper.
`timescale 1ns / 1ps

// Usage
//  in_ch  : one raw text byte per item, starting at the opening quote;
//           text_ends marks the last byte of the text.
//  out_ch : decoded results, one per item: a byte (has_byte), the closing
//           quote mark (string_done) or an error code. last_of_run flags the
//           final result caused by one input byte.
// Timing
//  A byte is decoded in the cycle it is accepted; its results sit in the run
//  register and the first is offered in the cycle after acceptance. Most
//  bytes give zero or one result, so one byte per cycle is sustained while
//  out_ch.ready is high. A passed-through \u escape gives six results (seven
//  with an error), one per cycle out of the run register while out_ch.ready
//  is high. Input is held off until the last result of a run is handed over;
//  a new byte is taken then, so the run register never leaves a bubble.
// Reset
//  arst_n clears the phase, the \u digit count and the run count: no result
//  is offered and the block waits for an opening quote.
// Stall
//  When out_ch.ready is low the current result holds and the input is held
//  off as soon as the run register has nothing left to free.

module json_string_unescape (
	input  logic             clk,
	input  logic             arst_n,
	jsu_in_if.sink           in_ch,
	jsu_out_if.source        out_ch
);

	// decoder state
	logic [1:0] phase_q;
	logic [1:0] dcnt_q;
	logic [7:0] held_q [3];

	// run register: results of the last byte, head at index 0
	jsu_pkg::result_t [jsu_pkg::MAX_RES-1:0] run_q;
	logic [2:0] cnt_q;

	jsu_pkg::step_t step;
	logic           in_acc;
	logic           out_acc;

	jsu_step u_step (
		.phase     (phase_q),
		.dcnt      (dcnt_q),
		.held0     (held_q[0]),
		.held1     (held_q[1]),
		.held2     (held_q[2]),
		.in_byte   (in_ch.in_byte),
		.text_ends (in_ch.text_ends),
		.step      (step)
	);

	// free when empty, or when the only result left leaves this cycle
	assign in_ch.ready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ch.ready);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_acc     = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_IDLE;
			dcnt_q  <= 2'd0;
			cnt_q   <= 3'd0;
		end else begin
			if (in_acc) begin
				phase_q <= step.phase;
				dcnt_q  <= step.dcnt;
				cnt_q   <= step.n;
			end else if (out_acc) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			run_q <= step.res;
			// the fourth \u character is used straight from the input
			if (step.hold_we && dcnt_q != 2'd3) held_q[dcnt_q] <= in_ch.in_byte;
		end else if (out_acc) begin
			for (int i = 0; i < jsu_pkg::MAX_RES - 1; i++) run_q[i] <= run_q[i+1];
		end
	end

	assign out_ch.valid       = (cnt_q != 3'd0);
	assign out_ch.out_byte    = run_q[0].data;
	assign out_ch.has_byte    = run_q[0].has;
	assign out_ch.string_done = run_q[0].done;
	assign out_ch.error_code  = run_q[0].err;
	assign out_ch.last_of_run = (cnt_q == 3'd1);

	// each result carries exactly one of byte, done mark, error
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> $countones({out_ch.has_byte, out_ch.string_done,
			out_ch.error_code != jsu_pkg::ERR_NONE}) == 1)
		else $error("result carries more or less than one kind");

	// input held off while more than one result is pending
	a_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q > 3'd1 |-> !in_ch.ready)
		else $error("input taken with a run still pending");

	// nothing follows the last of a run unless a new byte came in
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_ch.last_of_run && !in_acc |=> !out_ch.valid)
		else $error("result after end of run");

	// an error returns the decoder to idle
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error_code != jsu_pkg::ERR_NONE |-> phase_q == jsu_pkg::PH_IDLE)
		else $error("decoder not idle after error");

	// an error is always the final result of its run
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error_code != jsu_pkg::ERR_NONE |-> out_ch.last_of_run)
		else $error("error not at end of run");

endmodule
